@@ src/vqcl_pkg.sv @@
// Shared types, constants and widths for the competitive-learning vector quantiser.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package vqcl_pkg;

  // Sizing
  localparam int PROTOS     = 256;
  localparam int COORD_BITS = 24;
  localparam int ACC_BITS   = 40;
  localparam int ETA_BITS   = 24;
  localparam int IDX_BITS   = 8;    // proto_index and winner fields
  localparam int COUNT_BITS = 9;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 2;

  localparam int IDX_W   = $clog2(PROTOS);
  localparam int MATCH_W = (IDX_W > IDX_BITS) ? IDX_W : IDX_BITS;
  localparam int CNT_W   = $clog2(PROTOS + 1);
  localparam int DIST_W  = 2 * COORD_BITS + 1;
  localparam int INC_W   = COORD_BITS + 1;

  // Register defaults
  localparam logic [ETA_BITS-1:0]   ETA_START_RST = ETA_BITS'(251658);
  localparam logic [ETA_BITS-1:0]   ETA_DEC_RST   = ETA_BITS'(25);
  localparam logic [COUNT_BITS-1:0] COUNT_RST     = COUNT_BITS'(4);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_TRAIN = 2'd1,
    OP_EPOCH = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ETA_START = 2'd0,
    CFG_ETA_DEC   = 2'd1,
    CFG_COUNT     = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]                   operation;
    logic [IDX_BITS-1:0]          proto_index;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
  } in_t;

  typedef struct packed {
    logic [IDX_BITS-1:0]          winner;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic                         training_done;
  } out_t;

  // Search token walking the row of cells
  typedef struct packed {
    logic                         valid;
    logic                         train;
    logic                         have;
    logic [DIST_W-1:0]            best_dist;
    logic [MATCH_W-1:0]           best_idx;
    logic signed [COORD_BITS-1:0] best_x;
    logic signed [COORD_BITS-1:0] best_y;
  } tok_t;

  // Controller to cells broadcast
  typedef struct packed {
    logic signed [COORD_BITS-1:0] pt_x;
    logic signed [COORD_BITS-1:0] pt_y;
    logic [MATCH_W-1:0]           idx;
    logic [CNT_W-1:0]             n;
    logic                         load_we;
    logic                         upd_we;
    logic [MATCH_W-1:0]           upd_idx;
    logic signed [INC_W-1:0]      inc_x;
    logic signed [INC_W-1:0]      inc_y;
    logic                         epoch;
  } bc_t;

endpackage

`default_nettype wire

@@ src/vqcl_in_if.sv @@
// Input channel: valid/ready handshake carrying one operation item.
// Depends on vqcl_pkg for the payload type.
`default_nettype none

interface vqcl_in_if;
  logic             valid;
  logic             ready;
  vqcl_pkg::in_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/vqcl_out_if.sv @@
// Result channel: valid/ready handshake carrying one result item.
// Depends on vqcl_pkg for the payload type.
`default_nettype none

interface vqcl_out_if;
  logic             valid;
  logic             ready;
  vqcl_pkg::out_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/vq_competitive_learning_unit.sv @@
// Top level of the competitive-learning vector quantiser: controller plus a
// row of prototype cells. Depends on vqcl_pkg, vqcl_in_if, vqcl_out_if, vqcl_ctrl, vqcl_cell.
//
// One item is processed at a time. Load and end-epoch go from the input transfer
// straight to the result stage; every cell folds its accumulator in parallel at
// epoch end. For train and read, each cell registers the squares and then their
// sum to form the distances, a search token walks the row of PROTOS cells one
// cell per cycle, then the rate product and its rounding are registered in turn
// to form the rounded increment. The next input transfer is taken as soon as the
// result sits in the output register, even if it has not yet been taken.
`default_nettype none

module vq_competitive_learning_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [vqcl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [vqcl_pkg::CFG_W-1:0]     cfg_data,
  vqcl_in_if.sink                             in_ch,
  vqcl_out_if.source                          out_ch
);

  vqcl_pkg::bc_t  bc;
  vqcl_pkg::tok_t tok_w [vqcl_pkg::PROTOS+1];

  vqcl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .bc         (bc),
    .tok_launch (tok_w[0]),
    .tok_tail   (tok_w[vqcl_pkg::PROTOS])
  );

  // row of prototype cells, token handed on each cycle
  for (genvar g = 0; g < vqcl_pkg::PROTOS; g++) begin : g_cell
    vqcl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (vqcl_pkg::MATCH_W'(g)),
      .bc       (bc),
      .tok_i    (tok_w[g]),
      .tok_o    (tok_w[g+1])
    );
  end

endmodule

`default_nettype wire

@@ src/vqcl_cell.sv @@
// One prototype cell: prototype, accumulator, distance to the broadcast point,
// and one stage of the nearest-prototype search token. Depends on vqcl_pkg.
`default_nettype none

module vqcl_cell (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [vqcl_pkg::MATCH_W-1:0] cell_idx,
  input  wire vqcl_pkg::bc_t                bc,
  input  wire vqcl_pkg::tok_t               tok_i,
  output vqcl_pkg::tok_t                    tok_o
);

  localparam int CW  = vqcl_pkg::COORD_BITS;
  localparam int AW  = vqcl_pkg::ACC_BITS;
  localparam int SW  = AW + 1;
  localparam int CMP = vqcl_pkg::MATCH_W + vqcl_pkg::CNT_W;

  logic signed [CW-1:0]           proto_x_r, proto_y_r;
  logic signed [AW-1:0]           acc_x_r, acc_y_r;
  logic [2*CW-1:0]                sq_x_r, sq_y_r;
  logic [vqcl_pkg::DIST_W-1:0]    dist_r;
  vqcl_pkg::tok_t                 tok_r, tok_nxt;

  logic signed [CW:0]             dx, dy;
  logic [CW-1:0]                  mag_x, mag_y;
  logic signed [SW-1:0]           psum_x, psum_y, asum_x, asum_y;
  logic                           hit_idx, hit_upd, active;

  function automatic logic signed [CW-1:0] sat_coord(input logic signed [SW-1:0] v);
    if ((&v[SW-1:CW-1]) || !(|v[SW-1:CW-1])) begin
      return v[CW-1:0];
    end
    return v[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  function automatic logic signed [AW-1:0] sat_acc(input logic signed [SW-1:0] v);
    if (v[SW-1] == v[SW-2]) begin
      return v[AW-1:0];
    end
    return v[SW-1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
  endfunction

  // distance terms
  assign dx    = (CW+1)'(bc.pt_x) - (CW+1)'(proto_x_r);
  assign dy    = (CW+1)'(bc.pt_y) - (CW+1)'(proto_y_r);
  assign mag_x = dx[CW] ? CW'(-dx) : dx[CW-1:0];
  assign mag_y = dy[CW] ? CW'(-dy) : dy[CW-1:0];

  // epoch and update sums
  assign psum_x = SW'(proto_x_r) + SW'(acc_x_r);
  assign psum_y = SW'(proto_y_r) + SW'(acc_y_r);
  assign asum_x = SW'(acc_x_r) + SW'(bc.inc_x);
  assign asum_y = SW'(acc_y_r) + SW'(bc.inc_y);

  assign hit_idx = (bc.idx == cell_idx);
  assign hit_upd = (bc.upd_idx == cell_idx);
  assign active  = {{vqcl_pkg::CNT_W{1'b0}}, cell_idx} < CMP'(bc.n);

  // squares, then their sum, registered
  always_ff @(posedge clk) begin
    sq_x_r <= mag_x * mag_x;
    sq_y_r <= mag_y * mag_y;
    dist_r <= vqcl_pkg::DIST_W'(sq_x_r) + vqcl_pkg::DIST_W'(sq_y_r);
  end

  // prototype store: load or fold in the accumulator at epoch end
  always_ff @(posedge clk) begin
    if (bc.load_we && hit_idx) begin
      proto_x_r <= bc.pt_x;
      proto_y_r <= bc.pt_y;
    end else if (bc.epoch) begin
      proto_x_r <= sat_coord(psum_x);
      proto_y_r <= sat_coord(psum_y);
    end
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r <= '0;
      acc_y_r <= '0;
    end else if (bc.epoch) begin
      acc_x_r <= '0;
      acc_y_r <= '0;
    end else if (bc.upd_we && hit_upd) begin
      acc_x_r <= sat_acc(asum_x);
      acc_y_r <= sat_acc(asum_y);
    end
  end

  // search token: strict less-than keeps the lower index on ties
  always_comb begin
    tok_nxt = tok_i;
    if (tok_i.valid) begin
      if (tok_i.train) begin
        if (active && (!tok_i.have || (dist_r < tok_i.best_dist))) begin
          tok_nxt.have      = 1'b1;
          tok_nxt.best_dist = dist_r;
          tok_nxt.best_idx  = cell_idx;
          tok_nxt.best_x    = proto_x_r;
          tok_nxt.best_y    = proto_y_r;
        end
      end else if (hit_idx) begin
        tok_nxt.best_x = proto_x_r;
        tok_nxt.best_y = proto_y_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire

@@ src/vqcl_ctrl.sv @@
// Controller: handshakes, configuration registers, learning rate, search
// launch, increment arithmetic and result register. Depends on vqcl_pkg, interfaces.
`default_nettype none

module vqcl_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [vqcl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [vqcl_pkg::CFG_W-1:0]     cfg_data,
  vqcl_in_if.sink                             in_ch,
  vqcl_out_if.source                          out_ch,
  output vqcl_pkg::bc_t                       bc,
  output vqcl_pkg::tok_t                      tok_launch,
  input  wire vqcl_pkg::tok_t                 tok_tail
);

  localparam int CW = vqcl_pkg::COORD_BITS;
  localparam int EW = vqcl_pkg::ETA_BITS;
  localparam int PW = EW + CW;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQ, ST_SUM, ST_LAUNCH, ST_RUN, ST_MUL, ST_RND, ST_DONE
  } state_t;

  state_t                            state_r;
  vqcl_pkg::op_t                     op_r;
  logic [vqcl_pkg::IDX_BITS-1:0]     idx_r;
  logic signed [CW-1:0]              pt_x_r, pt_y_r, bx_r, by_r;
  logic [vqcl_pkg::MATCH_W-1:0]      win_r;
  logic [PW-1:0]                     prod_x_r, prod_y_r;
  logic                              neg_x_r, neg_y_r;
  logic signed [vqcl_pkg::INC_W-1:0] inc_x_r, inc_y_r;
  logic [EW-1:0]                     eta_r, eta_dec_r, eta_nxt;
  logic [vqcl_pkg::COUNT_BITS-1:0]   count_r;
  logic                              out_valid_r;
  vqcl_pkg::out_t                    out_r;

  logic                              commit;
  logic signed [CW:0]                dx, dy;
  logic [CW-1:0]                     mag_x, mag_y;
  logic [PW:0]                       rnd_x, rnd_y;
  logic [vqcl_pkg::INC_W-1:0]        r_x, r_y;
  logic [vqcl_pkg::CNT_W-1:0]        n_eff;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  assign commit  = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  assign eta_nxt = (eta_r > eta_dec_r) ? eta_r - eta_dec_r : '0;

  // point minus winner, magnitude for the rate product
  assign dx    = (CW+1)'(pt_x_r) - (CW+1)'(bx_r);
  assign dy    = (CW+1)'(pt_y_r) - (CW+1)'(by_r);
  assign mag_x = dx[CW] ? CW'(-dx) : dx[CW-1:0];
  assign mag_y = dy[CW] ? CW'(-dy) : dy[CW-1:0];

  // round to nearest, halves away from zero (applied to the magnitude)
  assign rnd_x = (PW+1)'(prod_x_r) + ((PW+1)'(1) << (EW - 1));
  assign rnd_y = (PW+1)'(prod_y_r) + ((PW+1)'(1) << (EW - 1));
  assign r_x   = rnd_x[PW:EW];
  assign r_y   = rnd_y[PW:EW];

  // searched prototype count, clamped to 1..PROTOS
  always_comb begin
    if (count_r == '0) begin
      n_eff = vqcl_pkg::CNT_W'(1);
    end else if (32'(count_r) > vqcl_pkg::PROTOS) begin
      n_eff = vqcl_pkg::CNT_W'(vqcl_pkg::PROTOS);
    end else begin
      n_eff = vqcl_pkg::CNT_W'(count_r);
    end
  end

  // broadcast to the cells
  always_comb begin
    bc.pt_x    = pt_x_r;
    bc.pt_y    = pt_y_r;
    bc.idx     = vqcl_pkg::MATCH_W'(idx_r);
    bc.n       = n_eff;
    bc.load_we = commit && (op_r == vqcl_pkg::OP_LOAD);
    bc.upd_we  = commit && (op_r == vqcl_pkg::OP_TRAIN);
    bc.upd_idx = win_r;
    bc.inc_x   = inc_x_r;
    bc.inc_y   = inc_y_r;
    bc.epoch   = commit && (op_r == vqcl_pkg::OP_EPOCH);
  end

  // search token entering the first cell
  always_comb begin
    tok_launch       = '0;
    tok_launch.valid = (state_r == ST_LAUNCH);
    tok_launch.train = (op_r == vqcl_pkg::OP_TRAIN);
  end

  // configuration, sequencing and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      eta_r       <= vqcl_pkg::ETA_START_RST;
      eta_dec_r   <= vqcl_pkg::ETA_DEC_RST;
      count_r     <= vqcl_pkg::COUNT_RST;
    end else begin
      if (cfg_we) begin
        case (vqcl_pkg::cfg_idx_t'(cfg_index))
          vqcl_pkg::CFG_ETA_START: begin
            // start rate only matters at reset, which restores its default
          end
          vqcl_pkg::CFG_ETA_DEC: eta_dec_r <= cfg_data[EW-1:0];
          vqcl_pkg::CFG_COUNT:   count_r   <= cfg_data[vqcl_pkg::COUNT_BITS-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            op_r   <= vqcl_pkg::op_t'(in_ch.data.operation);
            idx_r  <= in_ch.data.proto_index;
            pt_x_r <= in_ch.data.coord_x;
            pt_y_r <= in_ch.data.coord_y;
            case (vqcl_pkg::op_t'(in_ch.data.operation))
              vqcl_pkg::OP_TRAIN, vqcl_pkg::OP_READ: state_r <= ST_SQ;
              default:                                state_r <= ST_DONE;
            endcase
          end
        end
        ST_SQ:     state_r <= ST_SUM;
        ST_SUM:    state_r <= ST_LAUNCH;
        ST_LAUNCH: state_r <= ST_RUN;
        ST_RUN: begin
          if (tok_tail.valid) begin
            win_r   <= tok_tail.best_idx;
            bx_r    <= tok_tail.best_x;
            by_r    <= tok_tail.best_y;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_x_r <= eta_r * mag_x;
          prod_y_r <= eta_r * mag_y;
          neg_x_r  <= dx[CW];
          neg_y_r  <= dy[CW];
          state_r  <= ST_RND;
        end
        ST_RND: begin
          inc_x_r <= neg_x_r ? -$signed(r_x) : $signed(r_x);
          inc_y_r <= neg_y_r ? -$signed(r_y) : $signed(r_y);
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (commit) begin
            out_valid_r <= 1'b1;
            out_r.winner        <= idx_r;
            out_r.out_x         <= '0;
            out_r.out_y         <= '0;
            out_r.training_done <= (eta_r == '0);
            case (op_r)
              vqcl_pkg::OP_TRAIN: begin
                out_r.winner <= win_r[vqcl_pkg::IDX_BITS-1:0];
                out_r.out_x  <= bx_r;
                out_r.out_y  <= by_r;
              end
              vqcl_pkg::OP_READ: begin
                out_r.out_x <= bx_r;
                out_r.out_y <= by_r;
              end
              vqcl_pkg::OP_EPOCH: begin
                eta_r               <= eta_nxt;
                out_r.training_done <= (eta_nxt == '0);
              end
              default: ;
            endcase
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // the search result only comes back while it is awaited
  a_tail_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    tok_tail.valid |-> (state_r == ST_RUN))
    else $error("search token left the row outside the run state");

  // at most one kind of cell update per cycle
  a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({bc.load_we, bc.upd_we, bc.epoch}))
    else $error("conflicting cell updates");

  // a committed item always yields a held result
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("committed item produced no result");

  // the learning rate never rises
  a_eta_falls: assert property (@(posedge clk) disable iff (!rst_n)
    eta_r <= $past(eta_r))
    else $error("learning rate increased");

endmodule

`default_nettype wire

@@ tb/vq_prediction_checker.sv @@
// Watches the configuration port and both channels of the quantiser, predicts every
// result from its own copy of prototypes, accumulators and eta, and compares in order.
// Depends on vqcl_pkg, vqcl_in_if and vqcl_out_if.
`timescale 1ns / 1ps

module vq_prediction_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [vqcl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vqcl_pkg::CFG_W-1:0]     cfg_data,
  vqcl_in_if                             in_ch,
  vqcl_out_if                            out_ch,
  output int                             pending,
  output int                             errors
);

  // shadow registers and state
  logic [vqcl_pkg::ETA_BITS-1:0]   eta_start_q;
  logic [vqcl_pkg::ETA_BITS-1:0]   eta_dec_q;
  logic [vqcl_pkg::COUNT_BITS-1:0] count_q;
  logic [vqcl_pkg::ETA_BITS-1:0]   eta_q;
  longint                          proto_x [vqcl_pkg::PROTOS];
  longint                          proto_y [vqcl_pkg::PROTOS];
  longint                          acc_x   [vqcl_pkg::PROTOS];
  longint                          acc_y   [vqcl_pkg::PROTOS];

  vqcl_pkg::out_t expected_results[$];

  assign pending = expected_results.size();

  function automatic longint clip(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // eta (unsigned Q0.24) * diff, rounded to an integer with halves away from zero
  function automatic longint learn_step(longint diff);
    longint mag;
    longint r;
    mag = (diff < 0) ? -diff : diff;
    r   = (longint'(eta_q) * mag + (longint'(1) <<< 23)) >>> 24;
    return (diff < 0) ? -r : r;
  endfunction

  function automatic longint sq_dist(longint ax, longint ay, longint bx, longint by);
    return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
  endfunction

  // applies one item to the shadow state and returns its result
  function automatic vqcl_pkg::out_t quantise_step(vqcl_pkg::in_t d);
    vqcl_pkg::out_t r;
    longint         cx;
    longint         cy;
    longint         best;
    longint         dd;
    int             n;
    int             win;
    cx = longint'(d.coord_x);
    cy = longint'(d.coord_y);
    r.winner = d.proto_index;
    r.out_x  = '0;
    r.out_y  = '0;
    case (vqcl_pkg::op_t'(d.operation))
      vqcl_pkg::OP_LOAD: begin
        proto_x[d.proto_index] = cx;
        proto_y[d.proto_index] = cy;
      end
      vqcl_pkg::OP_TRAIN: begin
        n = (count_q == 0) ? 1 :
            ((count_q > vqcl_pkg::PROTOS) ? vqcl_pkg::PROTOS : int'(count_q));
        win  = 0;
        best = sq_dist(cx, cy, proto_x[0], proto_y[0]);
        for (int i = 1; i < n; i++) begin
          dd = sq_dist(cx, cy, proto_x[i], proto_y[i]);
          if (dd < best) begin
            best = dd;
            win  = i;
          end
        end
        r.winner = vqcl_pkg::IDX_BITS'(win);
        r.out_x  = vqcl_pkg::COORD_BITS'(proto_x[win]);
        r.out_y  = vqcl_pkg::COORD_BITS'(proto_y[win]);
        acc_x[win] = clip(acc_x[win] + learn_step(cx - proto_x[win]), vqcl_pkg::ACC_BITS);
        acc_y[win] = clip(acc_y[win] + learn_step(cy - proto_y[win]), vqcl_pkg::ACC_BITS);
      end
      vqcl_pkg::OP_EPOCH: begin
        for (int i = 0; i < vqcl_pkg::PROTOS; i++) begin
          proto_x[i] = clip(proto_x[i] + acc_x[i], vqcl_pkg::COORD_BITS);
          proto_y[i] = clip(proto_y[i] + acc_y[i], vqcl_pkg::COORD_BITS);
          acc_x[i] = 0;
          acc_y[i] = 0;
        end
        eta_q = (eta_q > eta_dec_q) ? eta_q - eta_dec_q : '0;
      end
      default: begin
        r.out_x = vqcl_pkg::COORD_BITS'(proto_x[d.proto_index]);
        r.out_y = vqcl_pkg::COORD_BITS'(proto_y[d.proto_index]);
      end
    endcase
    r.training_done = (eta_q == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    vqcl_pkg::out_t exp_r;
    vqcl_pkg::out_t got;
    if (!rst_n) begin
      eta_start_q = vqcl_pkg::ETA_START_RST;
      eta_dec_q   = vqcl_pkg::ETA_DEC_RST;
      count_q     = vqcl_pkg::COUNT_RST;
      eta_q       = vqcl_pkg::ETA_START_RST;
      for (int i = 0; i < vqcl_pkg::PROTOS; i++) begin
        proto_x[i] = 0;
        proto_y[i] = 0;
        acc_x[i]   = 0;
        acc_y[i]   = 0;
      end
      expected_results.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (vqcl_pkg::cfg_idx_t'(cfg_index))
          vqcl_pkg::CFG_ETA_START: eta_start_q = cfg_data[vqcl_pkg::ETA_BITS-1:0];
          vqcl_pkg::CFG_ETA_DEC:   eta_dec_q   = cfg_data[vqcl_pkg::ETA_BITS-1:0];
          vqcl_pkg::CFG_COUNT:     count_q     = cfg_data[vqcl_pkg::COUNT_BITS-1:0];
          default: ;
        endcase
      end
      // result transfer compared against the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.winner !== exp_r.winner) begin
            $display("%0t: winner exp %0d got %0d", $time, exp_r.winner, got.winner);
            errors++;
          end
          if (got.out_x !== exp_r.out_x) begin
            $display("%0t: out_x exp %0d got %0d", $time, exp_r.out_x, got.out_x);
            errors++;
          end
          if (got.out_y !== exp_r.out_y) begin
            $display("%0t: out_y exp %0d got %0d", $time, exp_r.out_y, got.out_y);
            errors++;
          end
          if (got.training_done !== exp_r.training_done) begin
            $display("%0t: training_done exp %0b got %0b", $time,
                     exp_r.training_done, got.training_done);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(quantise_step(in_ch.data));
    end
  end

endmodule

@@ tb/testbench.sv @@
// Stimulus and verdict for vq_competitive_learning_unit: loads prototypes, drives
// directed and random load/train/epoch/read traffic over several register settings.
// Depends on vqcl_pkg, the channel interfaces and vq_prediction_checker.
`timescale 1ns / 1ps

module testbench;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [vqcl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [vqcl_pkg::CFG_W-1:0]     cfg_data = '0;

  int pending;
  int errors;
  int snd_idle = 0;
  int rcv_idle = 0;
  bit hold_trig = 1'b0;

  vqcl_in_if  in_ch ();
  vqcl_out_if out_ch ();

  vq_competitive_learning_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  vq_prediction_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .pending   (pending),
    .errors    (errors)
  );

  always #5 clk = ~clk;

  // receiver: random stalls, plus a long hold-off on each toggle of hold_trig
  initial begin
    bit seen;
    int hold_left;
    seen = 1'b0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_trig != seen) begin
        seen = hold_trig;
        hold_left = 800;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  task automatic cfg_write(vqcl_pkg::cfg_idx_t idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= vqcl_pkg::CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // one input transfer, with random idle cycles ahead of it
  task automatic send(logic [1:0] op, int idx, int x, int y);
    vqcl_pkg::in_t d;
    d.operation   = op;
    d.proto_index = vqcl_pkg::IDX_BITS'(idx);
    d.coord_x     = vqcl_pkg::COORD_BITS'(x);
    d.coord_y     = vqcl_pkg::COORD_BITS'(y);
    if ($urandom_range(99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= d;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic int rand_coord();
    int r;
    r = $urandom_range(99);
    if (r < 20) return int'($urandom) <<< 8 >>> 8;
    if (r < 23) return 8388607;
    if (r < 26) return -8388608;
    return $urandom_range(32767) - 16384;
  endfunction

  task automatic random_items(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 8)
        send(vqcl_pkg::OP_LOAD, $urandom_range(255), rand_coord(), rand_coord());
      else if (r < 80)
        send(vqcl_pkg::OP_TRAIN, $urandom_range(255), rand_coord(), rand_coord());
      else if (r < 85)
        send(vqcl_pkg::OP_EPOCH, $urandom_range(255), rand_coord(), rand_coord());
      else
        send(vqcl_pkg::OP_READ, $urandom_range(255), rand_coord(), rand_coord());
      if (k == count / 2 && snd_idle < 10) hold_trig = ~hold_trig;
    end
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle = 6;
    rcv_idle = 77;
    // every slot written before anything reads it
    for (int i = 0; i < vqcl_pkg::PROTOS; i++)
      send(vqcl_pkg::OP_LOAD, i, rand_coord(), rand_coord());

    // directed: coordinate extremes, a distance tie, epoch and reads
    send(vqcl_pkg::OP_LOAD, 0, 8388607, 8388607);
    send(vqcl_pkg::OP_LOAD, 1, -8388608, -8388608);
    send(vqcl_pkg::OP_LOAD, 2, 0, 0);
    send(vqcl_pkg::OP_LOAD, 3, 0, 0);
    send(vqcl_pkg::OP_READ, 0, 0, 0);
    send(vqcl_pkg::OP_READ, 1, -1, -1);
    send(vqcl_pkg::OP_READ, 255, 0, 0);
    send(vqcl_pkg::OP_TRAIN, 0, 8388607, 8388607);
    send(vqcl_pkg::OP_TRAIN, 0, -8388608, -8388608);
    send(vqcl_pkg::OP_TRAIN, 0, 0, 0);
    send(vqcl_pkg::OP_TRAIN, 0, 8388607, -8388608);
    send(vqcl_pkg::OP_TRAIN, 0, -8388608, 8388607);
    send(vqcl_pkg::OP_EPOCH, 0, 0, 0);
    send(vqcl_pkg::OP_READ, 0, 0, 0);
    send(vqcl_pkg::OP_READ, 1, 0, 0);
    send(vqcl_pkg::OP_READ, 2, 0, 0);
    send(vqcl_pkg::OP_READ, 3, 0, 0);
    send(vqcl_pkg::OP_LOAD, 255, -1, 1);
    send(vqcl_pkg::OP_READ, 255, 0, 0);
    drain();

    random_items(250);
    cfg_write(vqcl_pkg::CFG_ETA_START, 0);
    cfg_write(vqcl_pkg::CFG_ETA_DEC, 0);
    cfg_write(vqcl_pkg::CFG_COUNT, 256);
    random_items(200);
    cfg_write(vqcl_pkg::CFG_ETA_DEC, 500000);
    cfg_write(vqcl_pkg::CFG_COUNT, 1);
    random_items(250);

    snd_idle = 77;
    rcv_idle = 6;
    cfg_write(vqcl_pkg::CFG_COUNT, 511);
    random_items(200);
    cfg_write(vqcl_pkg::CFG_COUNT, 0);
    cfg_write(vqcl_pkg::CFG_ETA_DEC, 16777215);
    random_items(250);

    snd_idle = 0;
    rcv_idle = 0;
    cfg_write(vqcl_pkg::CFG_ETA_START, 16777215);
    cfg_write(vqcl_pkg::CFG_ETA_DEC, 1);
    cfg_write(vqcl_pkg::CFG_COUNT, 17);
    random_items(250);
    repeat (10) @(posedge clk);

    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ vq_competitive_learning_unit.f @@
src/vqcl_pkg.sv
src/vqcl_in_if.sv
src/vqcl_out_if.sv
src/vqcl_cell.sv
src/vqcl_ctrl.sv
src/vq_competitive_learning_unit.sv
tb/vq_prediction_checker.sv
tb/testbench.sv
